/* hdl/fbpa_pkg.sv */
// Shared constants, types and codes for the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

  localparam int BLOCK_TOTAL  = 64;
  localparam int BLOCK_BYTES  = 64;   // power of two: block index is a shift
  localparam int HEADER_BYTES = 8;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 32;
  localparam int IDX_W   = $clog2(BLOCK_TOTAL);
  localparam int LINK_W  = $clog2(BLOCK_TOTAL + 1);
  localparam int SHIFT_W = $clog2(BLOCK_BYTES);

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(BLOCK_TOTAL);
  localparam logic [LINK_W-1:0] HEAD_RST  = LINK_W'(BLOCK_TOTAL - 1);

  localparam logic [SIZE_W-1:0] PAYLOAD_MAX = SIZE_W'(BLOCK_BYTES - HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HEADER_OFS  = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W:0]   POOL_SPAN   = (ADDR_W + 1)'(BLOCK_TOTAL * BLOCK_BYTES);

  typedef enum logic [2:0] {
    OUT_POOL_ALLOC = 3'd0,
    OUT_TOO_LARGE  = 3'd1,
    OUT_POOL_EMPTY = 3'd2,
    OUT_FREED      = 3'd3,
    OUT_EXT_FREE   = 3'd4,
    OUT_NULL_FREE  = 3'd5
  } outcome_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // carry out the captured request
  } ctl_cmd_t;

endpackage
`default_nettype wire

/* hdl/fbpa_ctrl.sv */
// Controller state machine: request acceptance, execute step and result strobe.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output fbpa_pkg::ctl_cmd_t     cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import fbpa_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    busy          = 1'b0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hdl/fbpa_datapath.sv */
// Datapath: base register, free-list head, link memory and result registers.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fbpa_pkg::ctl_cmd_t          cmd,
  input  wire logic                        cfg_we,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] cfg_data,
  input  wire logic                        in_operation,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] in_free_address,
  output logic [fbpa_pkg::ADDR_W-1:0]      out_block_address,
  output logic [2:0]                       out_outcome
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic [LINK_W-1:0] head_r, head_nxt;

  // captured request
  op_t               op_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;

  // link memory, registered read at the head index
  logic [LINK_W-1:0]      link_mem [BLOCK_TOTAL];
  logic [BLOCK_TOTAL-1:0] valid_r;
  logic [LINK_W-1:0]      rd_data_r;
  logic                   rd_valid_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [IDX_W-1:0]       head_idx;
  logic [LINK_W-1:0]      head_link;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;

  logic [ADDR_W:0]   pool_limit;
  logic [ADDR_W-1:0] offset;
  logic              in_pool;
  logic [ADDR_W-1:0] alloc_addr;

  outcome_t          outcome_nxt;
  logic [ADDR_W-1:0] block_addr_nxt;
  logic [ADDR_W-1:0] block_addr_r;
  outcome_t          outcome_r;

  assign head_idx = head_r[IDX_W-1:0];

  // Unwritten entries read as their reset link: i-1, null for entry 0.
  always_comb begin
    if (rd_valid_r) begin
      head_link = rd_data_r;
    end else if (rd_idx_r == '0) begin
      head_link = LINK_NULL;
    end else begin
      head_link = LINK_W'(rd_idx_r) - LINK_W'(1);
    end
  end

  assign pool_limit = {1'b0, base_r} + POOL_SPAN;
  assign offset     = addr_r - base_r;
  assign in_pool    = (addr_r >= base_r) && ({1'b0, addr_r} < pool_limit);
  assign alloc_addr = base_r + (ADDR_W'(head_idx) << SHIFT_W) + HEADER_OFS;

  always_comb begin
    head_nxt       = head_r;
    wr_en          = 1'b0;
    wr_idx         = offset[SHIFT_W +: IDX_W];
    block_addr_nxt = '0;
    outcome_nxt    = OUT_POOL_ALLOC;
    case (op_r)
      OP_ALLOC: begin
        if (size_r > PAYLOAD_MAX) begin
          outcome_nxt = OUT_TOO_LARGE;
        end else if (head_r >= LINK_NULL) begin
          outcome_nxt = OUT_POOL_EMPTY;
        end else begin
          head_nxt       = head_link;
          block_addr_nxt = alloc_addr;
          outcome_nxt    = OUT_POOL_ALLOC;
        end
      end
      OP_FREE: begin
        if (addr_r == '0) begin
          outcome_nxt = OUT_NULL_FREE;
        end else if (in_pool) begin
          wr_en       = 1'b1;
          head_nxt    = LINK_W'(offset[SHIFT_W +: IDX_W]);
          outcome_nxt = OUT_FREED;
        end else begin
          outcome_nxt = OUT_EXT_FREE;
        end
      end
      default: begin
        outcome_nxt = OUT_EXT_FREE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      link_mem[wr_idx] <= head_r;
    end
    rd_data_r <= link_mem[head_idx];
    rd_idx_r  <= head_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      head_r     <= HEAD_RST;
      base_r     <= '0;
    end else begin
      rd_valid_r <= valid_r[head_idx];
      if (cmd.exec) begin
        head_r <= head_nxt;
        if (wr_en) valid_r[wr_idx] <= 1'b1;
      end
      if (cfg_we) base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      size_r <= in_request_size;
      addr_r <= in_free_address;
    end
    if (cmd.exec) begin
      block_addr_r <= block_addr_nxt;
      outcome_r    <= outcome_nxt;
    end
  end

  assign out_block_address = block_addr_r;
  assign out_outcome       = outcome_r;

endmodule
`default_nettype wire

/* hdl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Fixed-size block pool allocator, 64 blocks of 64 bytes on a LIFO free list.
//
// Request channel: drive in_operation (0 alloc, 1 free), in_request_size and
// in_free_address with start high; the request is taken at a clock edge where
// start is high and busy is low. busy is high for the one execute cycle.
// Result channel: out_valid pulses for exactly one cycle with
// out_block_address and out_outcome. The receiver cannot stall it.
// The result strobe is registered from the execute state. No new request is
// taken while busy is high; the link memory has a registered read of the
// head entry, which takes the cycle after acceptance.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the pool base address;
// cfg_ready is always high. Write it only while no request is in flight.
// Reset (rst_n low, synchronous): head = block 63, every link entry reads as
// its initial value (entry i links i-1, entry 0 ends the list) through
// per-entry valid bits, base address = 0. No clearing pass is needed.
module fixed_block_pool_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_operation,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] in_request_size,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] in_free_address,
  output logic                             out_valid,
  output logic [fbpa_pkg::ADDR_W-1:0]      out_block_address,
  output logic [2:0]                       out_outcome,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] cfg_data
);
  import fbpa_pkg::*;

  ctl_cmd_t cmd;

  // base register is always writable
  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fbpa_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_free_address   (in_free_address),
    .out_block_address (out_block_address),
    .out_outcome       (out_outcome)
  );

  // An accepted request is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request not executed");

  // Execute lasts a single cycle and is followed by the result strobe.
  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("execute not followed by result");

  // A result strobe only follows an execute cycle.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("spurious result strobe");

  // Only a pool allocation returns a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != OUT_POOL_ALLOC)) |-> (out_block_address == '0))
    else $error("nonzero address on non-allocation result");

endmodule
`default_nettype wire

/* tb/sv/fbpa_checker.sv */
// Reply checker for the block pool allocator: free-list predictor and field compare.
`timescale 1ns / 1ps
module fbpa_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_operation,
  input  logic [fbpa_pkg::SIZE_W-1:0] in_request_size,
  input  logic [fbpa_pkg::ADDR_W-1:0] in_free_address,
  input  logic                        out_valid,
  input  logic [fbpa_pkg::ADDR_W-1:0] out_block_address,
  input  logic [2:0]                  out_outcome,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [fbpa_pkg::ADDR_W-1:0] cfg_data,
  output int                          mismatches,
  output int                          awaited,
  output int                          checked,
  output int                          grants,
  output int                          returns
);
  import fbpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    outcome_t          outcome;
  } reply_t;

  reply_t            owed_replies[$];
  logic [ADDR_W-1:0] pool_base;
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] free_link [BLOCK_TOTAL];

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("tb: mismatch at %0t: %s", $time, msg);
  endtask

  // Pops or pushes the shadow free list and forms the reply for one request.
  task automatic serve_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, output reply_t r);
    logic [ADDR_W:0]   pool_limit;
    logic [ADDR_W-1:0] ofs;
    logic [IDX_W-1:0]  blk;
    begin
      r.addr = '0;
      pool_limit = {1'b0, pool_base} + POOL_SPAN;
      if (op == OP_ALLOC) begin
        if (size > PAYLOAD_MAX) begin
          r.outcome = OUT_TOO_LARGE;
        end else if (free_head >= LINK_NULL) begin
          r.outcome = OUT_POOL_EMPTY;
        end else begin
          blk = free_head[IDX_W-1:0];
          free_head = free_link[blk];
          r.addr = pool_base + ADDR_W'(blk) * ADDR_W'(BLOCK_BYTES) + HEADER_OFS;
          r.outcome = OUT_POOL_ALLOC;
        end
      end else if (addr == '0) begin
        // null is tested first, even when the pool covers address zero
        r.outcome = OUT_NULL_FREE;
      end else if (addr >= pool_base && {1'b0, addr} < pool_limit) begin
        ofs = addr - pool_base;
        blk = IDX_W'(ofs / BLOCK_BYTES);
        free_link[blk] = free_head;
        free_head = LINK_W'(blk);
        r.outcome = OUT_FREED;
      end else begin
        r.outcome = OUT_EXT_FREE;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t made;
    if (!rst_n) begin
      pool_base = '0;
      free_head = HEAD_RST;
      free_link[0] = LINK_NULL;
      for (int i = 1; i < BLOCK_TOTAL; i++) free_link[i] = LINK_W'(i - 1);
      owed_replies.delete();
      mismatches = 0;
      checked = 0;
      grants = 0;
      returns = 0;
    end else begin
      // a reply leaving at this edge belongs to an earlier request
      if (out_valid) begin
        if (owed_replies.size() == 0) begin
          report_mismatch($sformatf("reply addr %h outcome %0d with no request outstanding",
                                    out_block_address, out_outcome));
        end else begin
          want = owed_replies.pop_front();
          checked++;
          if (want.outcome == OUT_POOL_ALLOC) grants++;
          if (want.outcome == OUT_FREED) returns++;
          if (out_block_address !== want.addr)
            report_mismatch($sformatf("block_address %h, predicted %h",
                                      out_block_address, want.addr));
          if (out_outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, predicted %0d",
                                      out_outcome, want.outcome));
        end
      end
      if (start && !busy) begin
        serve_request(in_operation, in_request_size, in_free_address, made);
        owed_replies.push_back(made);
      end
      if (cfg_valid && cfg_ready) pool_base = cfg_data;
    end
    awaited = owed_replies.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the block pool allocator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import fbpa_pkg::*;

  // No progress on any channel for this long means the block hung.
  localparam int STALL_LIMIT   = 3000;
  // Extra idle clocks after the last reply, as margin before the verdict.
  localparam int SETTLE_CYCLES = 4;
  localparam logic [ADDR_W-1:0] POOL_BYTES = ADDR_W'(BLOCK_TOTAL * BLOCK_BYTES);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [SIZE_W-1:0] in_request_size;
  logic [ADDR_W-1:0] in_free_address;
  logic              out_valid;
  logic [ADDR_W-1:0] out_block_address;
  logic [2:0]        out_outcome;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  int mismatches, awaited, checked, grants, returns;

  // Payload addresses the pool has handed out and the stimulus still holds.
  logic [ADDR_W-1:0] live_blocks[$];
  logic [ADDR_W-1:0] base_now;
  bit                track_live;
  bit                draining;
  int                drain_mark;
  int                empties_seen;
  int                idle_pct;
  int                base_writes;

  always #1 clk = ~clk;

  fixed_block_pool_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_outcome       (out_outcome),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  fbpa_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_outcome       (out_outcome),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .awaited           (awaited),
    .checked           (checked),
    .grants            (grants),
    .returns           (returns)
  );

  // Replies are stable at the falling edge; collect grants there so the
  // stimulus, which moves on rising edges, never races with this list.
  always @(negedge clk) begin
    if (out_valid && out_outcome == OUT_POOL_EMPTY) empties_seen++;
    if (track_live && out_valid && out_outcome == OUT_POOL_ALLOC)
      live_blocks.push_back(out_block_address);
  end

  // Watchdog: any accepted request, reply or register write resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: no progress for %0d cycles, %0d replies outstanding", STALL_LIMIT, awaited);
    $display("tb: failure");
    $finish;
  end

  // One request: optional idle gap, then hold start until busy is seen low at a
  // falling edge; the next rising edge takes it. Returns on that edge with
  // start still high, so back-to-back requests keep it up.
  task automatic issue(input logic op, input logic [SIZE_W-1:0] size,
                       input logic [ADDR_W-1:0] addr);
    int gap;
    begin
      gap = 0;
      while (gap < 100 && idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start           <= 1'b1;
      in_operation    <= op;
      in_request_size <= size;
      in_free_address <= addr;
      do @(negedge clk); while (busy);
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted reply has been seen.
  task automatic hold_requests;
    start <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (2) @(posedge clk);
  endtask

  // Move the pool while idle; held addresses move with it, so they still
  // name the same blocks.
  task automatic write_base(input logic [ADDR_W-1:0] value);
    hold_requests();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    foreach (live_blocks[i]) live_blocks[i] = live_blocks[i] - base_now + value;
    base_now = value;
    base_writes++;
  endtask

  // Give back a block we hold, hitting anywhere in its header or payload.
  task automatic free_live_block;
    int idx;
    logic [ADDR_W-1:0] a;
    begin
      idx = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[idx];
      live_blocks.delete(idx);
      issue(OP_FREE, $urandom, a - HEADER_OFS + ADDR_W'($urandom_range(BLOCK_BYTES - 1)));
    end
  endtask

  // Mostly well-formed traffic that sweeps the pool from full to empty and
  // back; the rest is oversize allocs, null and stray frees.
  task automatic random_request(input bit stray_ok, input int noise_pct);
    int pick;
    logic [SIZE_W-1:0] sz;
    begin
      if (draining && (empties_seen >= drain_mark + 3 ||
                       live_blocks.size() >= 2 * BLOCK_TOTAL)) begin
        draining = 1'b0;
      end else if (!draining && live_blocks.size() == 0) begin
        draining = 1'b1;
        drain_mark = empties_seen;
      end
      if ($urandom_range(99) < noise_pct) begin
        pick = $urandom_range(stray_ok ? 6 : 5);
        case (pick)
          0: issue(OP_ALLOC, $urandom, $urandom);
          1: issue(OP_ALLOC, PAYLOAD_MAX + SIZE_W'($urandom_range(1, 8)), $urandom);
          2: issue(OP_FREE, $urandom, '0);
          3: issue(OP_FREE, $urandom, $urandom);
          4: issue(OP_FREE, $urandom, base_now + POOL_BYTES + ADDR_W'($urandom_range(3)));
          5: issue(OP_FREE, $urandom, base_now - 1 - ADDR_W'($urandom_range(3)));
          // in-pool address that may hit a block already on the list
          default: issue(OP_FREE, $urandom,
                         base_now + ADDR_W'($urandom_range(BLOCK_TOTAL * BLOCK_BYTES - 1)));
        endcase
      end else if (live_blocks.size() == 0 || $urandom_range(99) < (draining ? 85 : 15)) begin
        sz = ($urandom_range(9) == 0) ? PAYLOAD_MAX : SIZE_W'($urandom_range(PAYLOAD_MAX));
        issue(OP_ALLOC, sz, $urandom);
      end else begin
        free_live_block();
      end
    end
  endtask

  // idle < 0: pick no idling or heavy idling at random for each stretch of 25.
  task automatic run_phase(input int items, input int idle, input bit stray_ok);
    for (int n = 0; n < items; n++) begin
      if (idle >= 0) idle_pct = idle;
      else if (n % 25 == 0) idle_pct = $urandom_range(1) ? 0 : 82;
      // now and then let the block drain completely mid-phase
      if ($urandom_range(199) == 0) hold_requests();
      random_request(stray_ok, 12);
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] twice_freed;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_ALLOC;
    in_request_size = '0;
    in_free_address = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    base_now        = '0;
    track_live      = 1'b0;
    draining        = 1'b1;
    drain_mark      = 0;
    empties_seen    = 0;
    idle_pct        = 0;
    base_writes     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, base 0 from reset: list starts at block 63 and goes down.
    issue(OP_ALLOC, '0, $urandom);                          // block 63
    issue(OP_ALLOC, PAYLOAD_MAX, $urandom);                 // largest fit, block 62
    issue(OP_ALLOC, PAYLOAD_MAX + 1, $urandom);             // one byte too many
    issue(OP_ALLOC, '1, '1);                                // all-ones size
    issue(OP_ALLOC, 32'd1, '0);                             // block 61
    issue(OP_FREE, '1, '0);                                 // null, though pool covers 0
    issue(OP_FREE, '0, POOL_BYTES);                         // first byte past the pool
    issue(OP_FREE, '0, '1);
    issue(OP_FREE, '0, 32'h8000_0000);
    issue(OP_FREE, '0, ADDR_W'(63 * BLOCK_BYTES));          // header byte of block 63
    issue(OP_FREE, '0, ADDR_W'(63 * BLOCK_BYTES - 1));      // last byte of block 62
    issue(OP_FREE, '0, ADDR_W'(61 * BLOCK_BYTES) + HEADER_OFS);
    issue(OP_ALLOC, PAYLOAD_MAX, '0);                       // LIFO: block 61 again
    issue(OP_FREE, '0, ADDR_W'(61 * BLOCK_BYTES) + HEADER_OFS);
    hold_requests();
    track_live = 1'b1;

    write_base(32'h0001_0000);
    run_phase(250, 0, 1'b0);
    write_base(ADDR_W'($urandom_range(32'hFFFF_EFFF)));
    run_phase(250, 82, 1'b0);
    write_base('0);
    run_phase(250, 22, 1'b0);

    // Pool ends exactly at the top of the address space. Double frees from
    // here on: the list may loop and never run empty again.
    write_base(32'hFFFF_F000);
    idle_pct = 0;
    issue(OP_ALLOC, '0, '0);
    hold_requests();
    if (live_blocks.size() > 0) begin
      twice_freed = live_blocks.pop_back();
      issue(OP_FREE, '0, twice_freed);
      issue(OP_FREE, '0, twice_freed + 1);
    end
    run_phase(180, -1, 1'b1);

    // Pool runs past 2^32: upper blocks wrap to low addresses.
    write_base(32'hFFFF_F800);
    run_phase(60, 82, 1'b1);
    write_base('1);
    run_phase(60, 0, 1'b1);

    hold_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d replies checked: %0d pool grants, %0d blocks returned, %0d refused or ignored",
             checked, grants, returns, checked - grants - returns);
    $display("tb: %0d pool base writes (zero, mid-range, top-aligned, wrapping), %0d empty-pool replies",
             base_writes, empties_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
